>>> src/bpjs_pkg.sv
`default_nettype none
package bpjs_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int MAX_TICKS_DEF = 63;
    localparam int KEY_W         = 64;
    localparam int TICK_W        = 16;
    localparam int PRIO_W        = 16;
    localparam int SEQ_W         = 32;
    localparam int BUDGET_W      = 32;
    localparam int RUN_W         = 6;
    localparam int COUNT_W       = 5;

    typedef enum logic [2:0] {
        MODE_ADD      = 3'd0,
        MODE_REMOVE   = 3'd1,
        MODE_PRIORITY = 3'd2,
        MODE_HOLD     = 3'd3,
        MODE_RESIDENT = 3'd4,
        MODE_SPEND    = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_RESIDENT = 2'd2
    } status_t;

    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
        logic [SEQ_W-1:0]         seq;
        logic [TICK_W-1:0]        tick_count;
        logic [TICK_W-1:0]        ticks_done;
        logic [TICK_W-1:0]        cost;
        logic                     held;
        status_t                  status;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic               match_found;
        logic               free_found;
        logic               best_found;
        logic [COUNT_W-1:0] pend;
        logic [COUNT_W-1:0] sel;
        logic [COUNT_W-1:0] res;
    } scan_stat_t;

endpackage
`default_nettype wire

>>> src/bpjs_if.sv
`default_nettype none
interface bpjs_in_if;
    import bpjs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [2:0]               mode;
    logic [KEY_W-1:0]         job_key;
    logic [TICK_W-1:0]        total_ticks;
    logic signed [PRIO_W-1:0] job_priority;
    logic [TICK_W-1:0]        tick_cost;
    logic                     hold;
    logic [BUDGET_W-1:0]      budget;

    modport source (output valid, mode, job_key, total_ticks, job_priority, tick_cost,
                    hold, budget, input ready);
    modport sink (input valid, mode, job_key, total_ticks, job_priority, tick_cost,
                  hold, budget, output ready);
endinterface

interface bpjs_out_if;
    import bpjs_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               ok;
    logic [KEY_W-1:0]   result_key;
    logic [TICK_W-1:0]  tick_index;
    logic [TICK_W-1:0]  tick_total;
    logic [RUN_W-1:0]   ticks_run;
    logic [COUNT_W-1:0] pending_count;
    logic [COUNT_W-1:0] selectable_count;
    logic [COUNT_W-1:0] resident_count;
    logic               next_valid;
    logic [KEY_W-1:0]   next_key;
    logic               last;

    modport source (output valid, kind, ok, result_key, tick_index, tick_total, ticks_run,
                    pending_count, selectable_count, resident_count, next_valid,
                    next_key, last, input ready);
    modport sink (input valid, kind, ok, result_key, tick_index, tick_total, ticks_run,
                  pending_count, selectable_count, resident_count, next_valid,
                  next_key, last, output ready);
endinterface
`default_nettype wire

>>> src/bpjs_ram.sv
`default_nettype none
module bpjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/bpjs_scan.sv
`default_nettype none
module bpjs_scan
    import bpjs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       clr,
    input  wire logic                       en,
    input  wire logic [$clog2(ENTRIES)-1:0] idx,
    input  wire logic                       vld,
    input  wire rec_t                       rec,
    input  wire logic [KEY_W-1:0]           key,
    output scan_stat_t                      stat,
    output logic [$clog2(ENTRIES)-1:0]      match_idx,
    output logic [$clog2(ENTRIES)-1:0]      free_idx,
    output logic [$clog2(ENTRIES)-1:0]      best_idx,
    output rec_t                            match_rec,
    output rec_t                            best_rec
);

    localparam int IDX_W = $clog2(ENTRIES);

    scan_stat_t stat_reg;
    logic [IDX_W-1:0] match_idx_reg, free_idx_reg, best_idx_reg;
    rec_t match_rec_reg, best_rec_reg;
    logic hit, sel, better;

    assign hit = vld && (rec.key == key);
    assign sel = vld && (rec.status != ST_RESIDENT) && !rec.held;
    assign better = sel && (!stat_reg.best_found || (rec.prio > best_rec_reg.prio)
                    || ((rec.prio == best_rec_reg.prio) && (rec.seq < best_rec_reg.seq)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else if (clr)
        begin
            stat_reg <= '0;
        end
        else if (en)
        begin
            if (hit && !stat_reg.match_found)
            begin
                stat_reg.match_found <= 1'b1;
            end
            if (!vld && !stat_reg.free_found)
            begin
                stat_reg.free_found <= 1'b1;
            end
            if (better)
            begin
                stat_reg.best_found <= 1'b1;
            end
            if (vld && (rec.status == ST_RESIDENT))
            begin
                stat_reg.res <= stat_reg.res + 1'b1;
            end
            if (vld && (rec.status != ST_RESIDENT))
            begin
                stat_reg.pend <= stat_reg.pend + 1'b1;
            end
            if (sel)
            begin
                stat_reg.sel <= stat_reg.sel + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (hit && !stat_reg.match_found)
            begin
                match_idx_reg <= idx;
                match_rec_reg <= rec;
            end
            if (!vld && !stat_reg.free_found)
            begin
                free_idx_reg <= idx;
            end
            if (better)
            begin
                best_idx_reg <= idx;
                best_rec_reg <= rec;
            end
        end
    end

    assign stat      = stat_reg;
    assign match_idx = match_idx_reg;
    assign free_idx  = free_idx_reg;
    assign best_idx  = best_idx_reg;
    assign match_rec = match_rec_reg;
    assign best_rec  = best_rec_reg;

endmodule
`default_nettype wire

>>> src/budgeted_priority_job_scheduler_core.sv
`default_nettype none
// Job table of ENTRIES records in one RAM, swept one entry per cycle by a single
// compare/count unit. Add, remove, set priority, set held and mark resident take
// two sweeps; spend takes one sweep per tick run plus one more, each followed by
// its result beat. The block takes one item at a time.
module budgeted_priority_job_scheduler_core
    import bpjs_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int MAX_TICKS = MAX_TICKS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    bpjs_in_if.sink     in_ch,
    bpjs_out_if.source  out_ch
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ACT, S_OUT} state_t;

    state_t state_reg, state_next;
    logic post_reg, post_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [ENTRIES-1:0] vbits_reg, vbits_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [RUN_W-1:0] ticks_reg, ticks_next;
    logic [BUDGET_W-1:0] spent_reg, spent_next;
    logic ok_reg, ok_next;

    mode_t mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [TICK_W-1:0] tin_reg, cin_reg;
    logic signed [PRIO_W-1:0] prio_reg;
    logic hold_reg;
    logic [BUDGET_W-1:0] budget_reg;

    logic o_valid_reg, o_valid_next;
    logic [1:0] o_kind_reg, o_kind_next;
    logic o_ok_reg, o_ok_next;
    logic [KEY_W-1:0] o_rkey_reg, o_rkey_next;
    logic [TICK_W-1:0] o_idx_reg, o_idx_next, o_tot_reg, o_tot_next;
    logic [RUN_W-1:0] o_run_reg, o_run_next;
    logic [COUNT_W-1:0] o_pend_reg, o_pend_next, o_sel_reg, o_sel_next;
    logic [COUNT_W-1:0] o_res_reg, o_res_next;
    logic o_nv_reg, o_nv_next;
    logic [KEY_W-1:0] o_nkey_reg, o_nkey_next;
    logic o_last_reg, o_last_next;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr;
    rec_t ram_wdata, ram_rdata, w_rec;
    logic [REC_W-1:0] ram_rbits;

    logic scan_clr;
    scan_stat_t stat;
    logic [IDX_W-1:0] match_idx, free_idx, best_idx;
    rec_t match_rec, best_rec;

    logic fits;
    logic [TICK_W-1:0] done_inc;

    bpjs_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rbits)
    );
    assign ram_rdata = rec_t'(ram_rbits);

    bpjs_scan #(.ENTRIES(ENTRIES)) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (scan_clr),
        .en        (rd_vld_reg),
        .idx       (rd_idx_reg),
        .vld       (vbits_reg[rd_idx_reg]),
        .rec       (ram_rdata),
        .key       (key_reg),
        .stat      (stat),
        .match_idx (match_idx),
        .free_idx  (free_idx),
        .best_idx  (best_idx),
        .match_rec (match_rec),
        .best_rec  (best_rec)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign done_inc = best_rec.ticks_done + 1'b1;
    assign fits = ((ticks_reg == '0) && (budget_reg != '0))
                  || (({1'b0, spent_reg} + (BUDGET_W + 1)'(best_rec.cost))
                      <= {1'b0, budget_reg});

    always_comb
    begin
        state_next   = state_reg;
        post_next    = post_reg;
        cnt_next     = cnt_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = cnt_reg[IDX_W-1:0];
        vbits_next   = vbits_reg;
        seq_next     = seq_reg;
        ticks_next   = ticks_reg;
        spent_next   = spent_reg;
        ok_next      = ok_reg;
        o_valid_next = o_valid_reg;
        o_kind_next  = o_kind_reg;
        o_ok_next    = o_ok_reg;
        o_rkey_next  = o_rkey_reg;
        o_idx_next   = o_idx_reg;
        o_tot_next   = o_tot_reg;
        o_run_next   = o_run_reg;
        o_pend_next  = o_pend_reg;
        o_sel_next   = o_sel_reg;
        o_res_next   = o_res_reg;
        o_nv_next    = o_nv_reg;
        o_nkey_next  = o_nkey_reg;
        o_last_next  = o_last_reg;
        scan_clr     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = match_idx;
        w_rec        = match_rec;
        ram_wdata    = match_rec;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_SCAN;
                    post_next  = 1'b0;
                    cnt_next   = '0;
                    ticks_next = '0;
                    spent_next = '0;
                    ok_next    = 1'b0;
                    scan_clr   = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != CNT_W'(ENTRIES))
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                if ((mode_reg == MODE_SPEND) || post_reg)
                begin
                    if ((mode_reg == MODE_SPEND) && (ticks_reg != RUN_W'(MAX_TICKS))
                        && stat.best_found && fits)
                    begin
                        w_rec            = best_rec;
                        w_rec.ticks_done = done_inc;
                        w_rec.status = (done_inc >= best_rec.tick_count) ? ST_RESIDENT
                                                                         : ST_RUNNING;
                        ram_we      = 1'b1;
                        ram_waddr   = best_idx;
                        ram_wdata   = w_rec;
                        ticks_next  = ticks_reg + 1'b1;
                        spent_next  = spent_reg + BUDGET_W'(best_rec.cost);
                        o_kind_next = (done_inc >= best_rec.tick_count) ? KIND_DONE
                                                                        : KIND_TICK;
                        o_ok_next   = 1'b0;
                        o_rkey_next = best_rec.key;
                        o_idx_next  = best_rec.ticks_done;
                        o_tot_next  = best_rec.tick_count;
                        o_run_next  = '0;
                        o_pend_next = '0;
                        o_sel_next  = '0;
                        o_res_next  = '0;
                        o_nv_next   = 1'b0;
                        o_nkey_next = '0;
                        o_last_next = 1'b0;
                    end
                    else
                    begin
                        o_kind_next = KIND_SUMMARY;
                        o_ok_next   = (mode_reg == MODE_SPEND) ? 1'b1 : ok_reg;
                        o_rkey_next = '0;
                        o_idx_next  = '0;
                        o_tot_next  = '0;
                        o_run_next  = ticks_reg;
                        o_pend_next = stat.pend;
                        o_sel_next  = stat.sel;
                        o_res_next  = stat.res;
                        o_nv_next   = stat.best_found;
                        o_nkey_next = stat.best_found ? best_rec.key : '0;
                        o_last_next = 1'b1;
                    end
                    o_valid_next = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    unique case (mode_reg)
                        MODE_ADD:
                        begin
                            if (!stat.match_found && stat.free_found)
                            begin
                                w_rec.key        = key_reg;
                                w_rec.prio       = prio_reg;
                                w_rec.seq        = seq_reg;
                                w_rec.tick_count = (tin_reg == '0) ? TICK_W'(1) : tin_reg;
                                w_rec.ticks_done = '0;
                                w_rec.cost       = (cin_reg == '0) ? TICK_W'(1) : cin_reg;
                                w_rec.held       = 1'b0;
                                w_rec.status     = ST_PENDING;
                                ram_we           = 1'b1;
                                ram_waddr        = free_idx;
                                ram_wdata        = w_rec;
                                vbits_next[free_idx] = 1'b1;
                                seq_next         = seq_reg + 1'b1;
                                ok_next          = 1'b1;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (stat.match_found)
                            begin
                                vbits_next[match_idx] = 1'b0;
                                ok_next = 1'b1;
                            end
                        end
                        MODE_PRIORITY:
                        begin
                            if (stat.match_found)
                            begin
                                w_rec.prio = prio_reg;
                                ram_we     = 1'b1;
                                ram_wdata  = w_rec;
                                ok_next    = 1'b1;
                            end
                        end
                        MODE_HOLD:
                        begin
                            if (stat.match_found)
                            begin
                                w_rec.held = hold_reg;
                                ram_we     = 1'b1;
                                ram_wdata  = w_rec;
                                ok_next    = 1'b1;
                            end
                        end
                        MODE_RESIDENT:
                        begin
                            if (stat.match_found && (match_rec.status != ST_RESIDENT))
                            begin
                                w_rec.ticks_done = match_rec.tick_count;
                                w_rec.status     = ST_RESIDENT;
                                w_rec.held       = 1'b0;
                                ram_we           = 1'b1;
                                ram_wdata        = w_rec;
                                ok_next          = 1'b1;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    post_next  = 1'b1;
                    cnt_next   = '0;
                    scan_clr   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    o_valid_next = 1'b0;
                    if (o_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        scan_clr   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            post_reg    <= 1'b0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            vbits_reg   <= '0;
            seq_reg     <= '0;
            ticks_reg   <= '0;
            spent_reg   <= '0;
            ok_reg      <= 1'b0;
            o_valid_reg <= 1'b0;
            o_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            post_reg    <= post_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            vbits_reg   <= vbits_next;
            seq_reg     <= seq_next;
            ticks_reg   <= ticks_next;
            spent_reg   <= spent_next;
            ok_reg      <= ok_next;
            o_valid_reg <= o_valid_next;
            o_last_reg  <= o_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        o_kind_reg <= o_kind_next;
        o_ok_reg   <= o_ok_next;
        o_rkey_reg <= o_rkey_next;
        o_idx_reg  <= o_idx_next;
        o_tot_reg  <= o_tot_next;
        o_run_reg  <= o_run_next;
        o_pend_reg <= o_pend_next;
        o_sel_reg  <= o_sel_next;
        o_res_reg  <= o_res_next;
        o_nv_reg   <= o_nv_next;
        o_nkey_reg <= o_nkey_next;
        if (in_ch.valid && in_ch.ready)
        begin
            mode_reg   <= mode_t'(in_ch.mode);
            key_reg    <= in_ch.job_key;
            tin_reg    <= in_ch.total_ticks;
            prio_reg   <= in_ch.job_priority;
            cin_reg    <= in_ch.tick_cost;
            hold_reg   <= in_ch.hold;
            budget_reg <= in_ch.budget;
        end
    end

    assign out_ch.valid            = o_valid_reg;
    assign out_ch.kind             = o_kind_reg;
    assign out_ch.ok               = o_ok_reg;
    assign out_ch.result_key       = o_rkey_reg;
    assign out_ch.tick_index       = o_idx_reg;
    assign out_ch.tick_total       = o_tot_reg;
    assign out_ch.ticks_run        = o_run_reg;
    assign out_ch.pending_count    = o_pend_reg;
    assign out_ch.selectable_count = o_sel_reg;
    assign out_ch.resident_count   = o_res_reg;
    assign out_ch.next_valid       = o_nv_reg;
    assign out_ch.next_key         = o_nkey_reg;
    assign out_ch.last             = o_last_reg;

    a_idle_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("output beat pending while idle");

    a_write_in_act: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_ACT))
        else $error("table write outside action step");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
        else $error("not ready after final beat");

    a_tick_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ticks_reg <= RUN_W'(MAX_TICKS))
        else $error("tick count over limit");

endmodule
`default_nettype wire
